// ----- sv/mwo_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and constants of the multiwave oscillator voice
// no dependencies

package mwo_pkg;

	// default build constants
	localparam int MWO_SAMPLE_RATE = 48000;
	localparam int MWO_SINE_DEPTH  = 1024;

	// configuration port widths
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// fixed-point constants
	localparam logic signed [15:0] ONE_Q14      = 16'sd16384;
	localparam logic [14:0]        HALF_PI_Q14  = 15'd25736;
	localparam logic [16:0]        GAIN_ONE     = 17'd65536;
	localparam logic [15:0]        DECAY_MUL    = 16'd64881;
	localparam logic [16:0]        GAIN_FLOOR   = 17'd3276;

	// input word kinds
	typedef enum logic [1:0] {
		KIND_NOTE_ON  = 2'd0,
		KIND_NOTE_REL = 2'd1,
		KIND_NOTE_OFF = 2'd2,
		KIND_TICK     = 2'd3
	} kind_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_SHAPE   = 2'd0,
		REG_OUTPUT_LEVEL = 2'd1
	} cfg_reg_t;

	// waveform codes, all other codes play the sine
	typedef enum logic [2:0] {
		SHAPE_SINE     = 3'd0,
		SHAPE_SQUARE   = 3'd1,
		SHAPE_TRIANGLE = 3'd2,
		SHAPE_SAW      = 3'd3
	} shape_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_WAVE,
		S_SHAPE,
		S_LEVEL,
		S_GAIN,
		S_DONE
	} mwo_state_t;

	// datapath step codes
	typedef enum logic [2:0] {
		STEP_NONE,
		STEP_WAVE,
		STEP_SHAPE,
		STEP_LEVEL,
		STEP_GAIN,
		STEP_COMMIT
	} dp_step_t;

	// command bundle from controller to datapath
	typedef struct packed {
		logic     note_on;
		logic     note_rel;
		logic     note_off;
		dp_step_t step;
	} mwo_cmd_t;

endpackage

// ----- sv/mwo_ctrl.sv -----
`timescale 1ns / 1ps
// controller of the oscillator voice: input handshake, tick sequencing,
// output valid flag; depends on mwo_pkg

module mwo_ctrl import mwo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	output logic       out_valid,
	input  logic       out_stall,
	input  logic       sounding,
	output mwo_cmd_t   cmd
);

	mwo_state_t state_q, state_d;
	logic       out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd.note_on   = 1'b0;
		cmd.note_rel  = 1'b0;
		cmd.note_off  = 1'b0;
		cmd.step      = STEP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (kind)
						KIND_NOTE_ON:  cmd.note_on  = 1'b1;
						KIND_NOTE_REL: cmd.note_rel = 1'b1;
						KIND_NOTE_OFF: cmd.note_off = 1'b1;
						KIND_TICK: begin
							// a silent voice swallows the tick
							if (sounding) begin
								state_d = S_WAVE;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_WAVE: begin
				cmd.step = STEP_WAVE;
				state_d  = S_SHAPE;
			end
			S_SHAPE: begin
				cmd.step = STEP_SHAPE;
				state_d  = S_LEVEL;
			end
			S_LEVEL: begin
				cmd.step = STEP_LEVEL;
				state_d  = S_GAIN;
			end
			S_GAIN: begin
				cmd.step = STEP_GAIN;
				state_d  = S_DONE;
			end
			S_DONE: begin
				// wait for a free output slot
				if (!out_valid_q || !out_stall) begin
					cmd.step = STEP_COMMIT;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step == STEP_COMMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// checks
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> state_q == S_DONE)
		else $error("result overwritten while output stalled");

	a_tick_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAVE) |-> ##4 (state_q == S_DONE))
		else $error("tick sequence length wrong");

	a_silent_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && kind == KIND_TICK && !sounding)
		|=> state_q == S_IDLE)
		else $error("tick on silent voice started a sample");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("output valid raised outside commit");

endmodule

// ----- sv/mwo_dp.sv -----
`timescale 1ns / 1ps
// datapath of the oscillator voice: voice state, pitch and sine tables,
// one shared multiplier and output registers; depends on mwo_pkg

module mwo_dp import mwo_pkg::*; #(
	parameter int SAMPLE_RATE      = MWO_SAMPLE_RATE,
	parameter int SINE_TABLE_DEPTH = MWO_SINE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mwo_cmd_t              cmd,
	input  logic [6:0]            note_number,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  sounding,
	output logic signed [15:0]    sample_value,
	output logic                  voice_active
);

	localparam int          IdxW        = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
	localparam logic [IdxW:0] DEPTH_W   = (IdxW + 1)'(SINE_TABLE_DEPTH);
	localparam logic [63:0] STEP_DEN    = 64'(32 * SAMPLE_RATE);
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// 2^31 * 2^((i+3)/12), rounded
	localparam logic [63:0] SEMITONE_RATIO [12] = '{
		64'd2553802834, 64'd2705659852, 64'd2866546760, 64'd3037000500,
		64'd3217589947, 64'd3408917802, 64'd3611622603, 64'd3826380858,
		64'd4053909305, 64'd4294967296, 64'd4550359342, 64'd4820937788
	};

	// taylor series denominators (2k)(2k+1)
	localparam logic [63:0] TAYLOR_DIV [7] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
	};

	typedef logic [31:0]        step_tab_t [128];
	typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];

	// phase step per midi note, kept modulo 2^32
	function automatic step_tab_t make_step_table();
		step_tab_t   tab;
		logic [63:0] num;
		for (int n = 0; n < 128; n++) begin
			num    = (64'd440 * SEMITONE_RATIO[n % 12]) << (n / 12);
			tab[n] = 32'((num + STEP_DEN / 2) / STEP_DEN);
		end
		return tab;
	endfunction

	// sine of a q30 angle, the angle plus seven further series terms
	function automatic logic [63:0] sin_q30(input logic [63:0] th);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = th;
		term = th;
		for (int k = 1; k <= 7; k++) begin
			term = (((term * th) >> 30) * th) >> 30;
			term = term / TAYLOR_DIV[k-1];
			if ((k % 2) != 0) sum = sum - term;
			else              sum = sum + term;
		end
		return sum;
	endfunction

	// q2.14 sine table built from quarter-wave symmetry
	function automatic sine_tab_t make_sine_table();
		sine_tab_t   tab;
		logic [63:0] t;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] a;
		logic [63:0] th;
		logic [63:0] m;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			t  = 64'(4 * i);
			q  = t / SINE_TABLE_DEPTH;
			r  = t % SINE_TABLE_DEPTH;
			a  = q[0] ? (64'(SINE_TABLE_DEPTH) - r) : r;
			th = (a * HALF_PI_Q30) / SINE_TABLE_DEPTH;
			m  = (sin_q30(th) + 64'd32768) >> 16;
			if (m > 64'(ONE_Q14)) m = 64'(ONE_Q14);
			tab[i] = q[1] ? -$signed(16'(m)) : $signed(16'(m));
		end
		return tab;
	endfunction

	localparam step_tab_t STEP_ROM = make_step_table();
	localparam sine_tab_t SINE_ROM = make_sine_table();

	// voice state
	logic [2:0]  wave_shape_q;
	logic [15:0] output_level_q;
	logic [31:0] phase_q;
	logic [31:0] step_q;
	logic [16:0] gain_q;
	logic        releasing_q;
	logic        sounding_q;

	// working registers of one tick
	logic signed [15:0] sin_q;
	logic               neg_q;
	logic signed [15:0] v_q;
	logic [16:0]        gain_nx_q;
	logic signed [50:0] mul_q;
	logic signed [15:0] sample_q;
	logic               active_q;

	logic [32+IdxW:0]   idx_prod;
	logic [IdxW-1:0]    sin_idx;
	logic [30:0]        mag;
	logic               neg_d;
	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] mul_p;
	logic [16:0]        gain_eff;
	logic [50:0]        shp_rnd;
	logic [14:0]        shp_mag;
	logic signed [15:0] tri_v;
	logic signed [15:0] wave_v;
	logic [50:0]        dec_rnd;
	logic [50:0]        p_abs;
	logic [50:0]        p_rnd;
	logic [19:0]        p_mag;
	logic signed [15:0] sat_v;
	logic               rel_end;

	// sine table address from the phase
	assign idx_prod = (33 + IdxW)'(phase_q) * (33 + IdxW)'(DEPTH_W);
	assign sin_idx  = idx_prod[31+IdxW:32];

	// folded phase for triangle and saw, saw runs at twice the rate
	assign mag   = phase_q[30] ? (31'h4000_0000 - {1'b0, phase_q[29:0]})
	                           : {1'b0, phase_q[29:0]};
	assign neg_d = (wave_shape_q == SHAPE_SAW) ? phase_q[30] : phase_q[31];

	assign gain_eff = releasing_q ? gain_q : GAIN_ONE;

	// shared multiplier operand select
	always_comb begin
		case (cmd.step)
			STEP_WAVE: begin
				mul_a = $signed({2'b00, mag});
				mul_b = $signed({3'b000, HALF_PI_Q14});
			end
			STEP_SHAPE: begin
				mul_a = $signed({16'd0, gain_q});
				mul_b = $signed({2'b00, DECAY_MUL});
			end
			STEP_LEVEL: begin
				mul_a = 33'(v_q);
				mul_b = $signed({2'b00, output_level_q});
			end
			STEP_GAIN: begin
				mul_a = $signed(mul_q[32:0]);
				mul_b = $signed({1'b0, gain_eff});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 51'(mul_a) * 51'(mul_b);

	// triangle and saw value, rounded to nearest
	assign shp_rnd = $unsigned(mul_q) + 51'h2000_0000;
	assign shp_mag = shp_rnd[44:30];
	assign tri_v   = neg_q ? -$signed({1'b0, shp_mag}) : $signed({1'b0, shp_mag});

	// waveform select
	always_comb begin
		case (wave_shape_q)
			SHAPE_SINE:     wave_v = sin_q;
			SHAPE_SQUARE:   wave_v = (sin_q > 16'sd0) ? ONE_Q14 : 16'sd0;
			SHAPE_TRIANGLE: wave_v = tri_v;
			SHAPE_SAW:      wave_v = tri_v;
			default:        wave_v = sin_q;
		endcase
	end

	// decayed release gain
	assign dec_rnd = $unsigned(mul_q) + 51'd32768;

	// sample rounding half away from zero, then saturation
	assign p_abs = mul_q[50] ? $unsigned(-mul_q) : $unsigned(mul_q);
	assign p_rnd = p_abs + 51'h4000_0000;
	assign p_mag = p_rnd[50:31];

	always_comb begin
		if (mul_q[50]) begin
			sat_v = (p_mag >= 20'd32768) ? 16'sh8000 : -$signed(p_mag[15:0]);
		end else begin
			sat_v = (p_mag >= 20'd32768) ? 16'sh7fff : $signed(p_mag[15:0]);
		end
	end

	assign rel_end = releasing_q && (gain_nx_q <= GAIN_FLOOR);

	// voice state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q   <= '0;
			output_level_q <= '0;
			phase_q        <= '0;
			step_q         <= '0;
			gain_q         <= '0;
			releasing_q    <= 1'b0;
			sounding_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WAVE_SHAPE) begin
					wave_shape_q <= cfg_data[2:0];
				end else if (cfg_index == REG_OUTPUT_LEVEL) begin
					output_level_q <= cfg_data;
				end
			end
			if (cmd.note_on) begin
				step_q      <= STEP_ROM[note_number];
				phase_q     <= '0;
				gain_q      <= '0;
				releasing_q <= 1'b0;
				sounding_q  <= 1'b1;
			end
			if (cmd.note_rel && !releasing_q) begin
				gain_q      <= GAIN_ONE;
				releasing_q <= 1'b1;
			end
			if (cmd.note_off) begin
				sounding_q     <= 1'b0;
				output_level_q <= '0;
				phase_q        <= '0;
			end
			if (cmd.step == STEP_COMMIT) begin
				phase_q <= phase_q + step_q;
				if (releasing_q) begin
					gain_q <= gain_nx_q;
				end
				// release has faded out
				if (rel_end) begin
					sounding_q     <= 1'b0;
					step_q         <= '0;
					output_level_q <= '0;
				end
			end
		end
	end

	// per-tick working registers
	always_ff @(posedge clk) begin
		if (cmd.step == STEP_WAVE) begin
			sin_q <= SINE_ROM[sin_idx];
			neg_q <= neg_d;
		end
		if (cmd.step == STEP_SHAPE) begin
			v_q <= wave_v;
		end
		if (cmd.step == STEP_LEVEL) begin
			gain_nx_q <= dec_rnd[32:16];
		end
		if (cmd.step == STEP_WAVE || cmd.step == STEP_SHAPE ||
		    cmd.step == STEP_LEVEL || cmd.step == STEP_GAIN) begin
			mul_q <= mul_p;
		end
		if (cmd.step == STEP_COMMIT) begin
			sample_q <= sat_v;
			active_q <= !rel_end;
		end
	end

	assign sounding     = sounding_q;
	assign sample_value = sample_q;
	assign voice_active = active_q;

endmodule

// ----- sv/multiwave_oscillator_with_release_top.sv -----
`timescale 1ns / 1ps
// top level of the multiwave oscillator voice with release
// instantiates mwo_ctrl and mwo_dp; depends on mwo_pkg
//
// usage
// - input channel in_valid/in_stall carries one word: kind and note_number
//   (note on, note off with release, note off immediate, sample tick)
// - output channel out_valid/out_stall carries sample_value (q2.14) and
//   voice_active, one word per tick of a sounding voice
// - configuration channel cfg_valid/cfg_ready, index 0 wave_shape,
//   index 1 output_level; cfg_ready is always high, writes land at once
// - note words are taken without stalling the input; a tick on a silent
//   voice is taken the same way and gives no word
// - a sounding tick stalls the input while it runs through the states wave,
//   shape, level, gain and done: four passes through the one shared
//   multiplier (the table read shares the first) and the rounding step;
//   the done state commits its word to the output register
// - the output register holds a finished word, so the next word is taken
//   while the receiver stalls; a second result waits in its last step
// - reset clears the voice registers and out_valid: voice silent, level zero

module multiwave_oscillator_with_release_top import mwo_pkg::*; #(
	parameter int SAMPLE_RATE      = MWO_SAMPLE_RATE,
	parameter int SINE_TABLE_DEPTH = MWO_SINE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            kind,
	input  logic [6:0]            note_number,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [15:0]    sample_value,
	output logic                  voice_active,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mwo_cmd_t cmd;
	logic     sounding;
	logic     cfg_we;

	// configuration writes never wait
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// controller
	mwo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sounding  (sounding),
		.cmd       (cmd)
	);

	// datapath
	mwo_dp #(
		.SAMPLE_RATE      (SAMPLE_RATE),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.note_number  (note_number),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sounding     (sounding),
		.sample_value (sample_value),
		.voice_active (voice_active)
	);

endmodule

// ----- bench/mwo_checker.sv -----
`timescale 1ns / 1ps
// checker for the multiwave oscillator voice: watches the input, output and
// configuration channels, predicts every output word and compares them
// depends on mwo_pkg

module mwo_checker import mwo_pkg::*; #(
	parameter int SAMPLE_RATE      = MWO_SAMPLE_RATE,
	parameter int SINE_TABLE_DEPTH = MWO_SINE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [1:0]            kind,
	input  logic [6:0]            note_number,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic signed [15:0]    sample_value,
	input  logic                  voice_active,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  wrap_up,
	output int                    pending,
	output int                    failures
);

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint signed   ROUND_HALF  = 64'sd1073741824;

	// 2^31 * 2^((i+3)/12), the twelve semitone ratios of one octave
	localparam longint unsigned SEMITONE_Q31 [12] = '{
		64'd2553802834, 64'd2705659852, 64'd2866546760, 64'd3037000500,
		64'd3217589947, 64'd3408917802, 64'd3611622603, 64'd3826380858,
		64'd4053909305, 64'd4294967296, 64'd4550359342, 64'd4820937788
	};

	typedef struct {
		logic signed [15:0] sample;
		logic               active;
	} voice_word_t;

	// predicted voice state and registers
	logic [2:0]         shape_r;
	logic [15:0]        level_r;
	logic [31:0]        phase_r;
	logic [31:0]        step_r;
	logic [16:0]        gain_r;
	logic               releasing_r;
	logic               sounding_r;
	logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

	voice_word_t due_samples [$];
	voice_word_t oldest;
	int          words_seen;
	int          samples_checked;
	int          fades_heard;
	logic [7:0]  shapes_heard;
	bit          wrapped;

	// fixed-point taylor series of sin, q30 angle in and out
	function automatic longint unsigned taylor_sin(input longint unsigned th);
		longint unsigned acc;
		longint unsigned term;
		acc = th;
		term = th;
		for (int k = 1; k <= 7; k++) begin
			term = ((term * th) >> 30) * th >> 30;
			term = term / longint'(4 * k * k + 2 * k);
			if (k % 2 == 1)
				acc -= term;
			else
				acc += term;
		end
		return acc;
	endfunction

	// one q2.14 entry of the sine table, folded from the first quadrant
	function automatic logic signed [15:0] sine_point(input int unsigned i);
		longint unsigned t;
		longint unsigned q;
		longint unsigned r;
		longint unsigned a;
		longint unsigned m;
		t = 64'd4 * i;
		q = t / SINE_TABLE_DEPTH;
		r = t % SINE_TABLE_DEPTH;
		a = q[0] ? SINE_TABLE_DEPTH - r : r;
		m = (taylor_sin(a * HALF_PI_Q30 / SINE_TABLE_DEPTH) + 64'd32768) >> 16;
		if (m > 64'd16384)
			m = 64'd16384;
		return q[1] ? -m[15:0] : m[15:0];
	endfunction

	// q30 fraction of a quarter turn to q2.14 angle, rounded
	function automatic int half_pi_scale(input longint unsigned m);
		return int'((m * HALF_PI_Q14 + (64'd1 << 29)) >> 30);
	endfunction

	// waveform value at a phase for the current shape register
	function automatic int wave_at(input logic [31:0] p);
		longint unsigned idx;
		longint unsigned m;
		int s;
		int v;
		idx = ({32'd0, p} * 64'(SINE_TABLE_DEPTH)) >> 32;
		s = sine_rom[idx];
		case (shape_r)
			SHAPE_SQUARE: return (s > 0) ? int'(ONE_Q14) : 0;
			SHAPE_TRIANGLE: begin
				m = p[30] ? (64'd1 << 30) - p[29:0] : {34'd0, p[29:0]};
				v = half_pi_scale(m);
				return p[31] ? -v : v;
			end
			SHAPE_SAW: begin
				if (!p[30])
					return half_pi_scale({34'd0, p[29:0]});
				return -half_pi_scale((64'd1 << 31) - p[30:0]);
			end
			default: return s;
		endcase
	endfunction

	// apply one input word to the voice, queue the sample it yields
	task automatic predict_voice_word(input kind_t k, input logic [6:0] n);
		longint unsigned num;
		longint unsigned den;
		longint v;
		longint g;
		longint prod;
		longint res;
		case (k)
			KIND_NOTE_ON: begin
				num = (64'd440 * SEMITONE_Q31[n % 12]) << (n / 12);
				den = 64'd32 * SAMPLE_RATE;
				step_r = 32'((num + den / 2) / den);
				phase_r = '0;
				gain_r = '0;
				releasing_r = 1'b0;
				sounding_r = 1'b1;
			end
			KIND_NOTE_REL: begin
				if (!releasing_r) begin
					gain_r = GAIN_ONE;
					releasing_r = 1'b1;
				end
			end
			KIND_NOTE_OFF: begin
				sounding_r = 1'b0;
				level_r = '0;
				phase_r = '0;
			end
			KIND_TICK: begin
				if (sounding_r) begin
					v = wave_at(phase_r);
					g = releasing_r ? longint'(gain_r) : longint'(GAIN_ONE);
					prod = v * longint'(level_r) * g;
					// round half away from zero, then saturate
					if (prod < 0)
						res = -((-prod + ROUND_HALF) >>> 31);
					else
						res = (prod + ROUND_HALF) >>> 31;
					if (res > 32767)
						res = 32767;
					if (res < -32768)
						res = -32768;
					shapes_heard[shape_r] = 1'b1;
					phase_r = phase_r + step_r;
					if (releasing_r) begin
						gain_r = 17'((longint'(gain_r) * DECAY_MUL + 32768) >> 16);
						if (gain_r <= GAIN_FLOOR) begin
							sounding_r = 1'b0;
							step_r = '0;
							level_r = '0;
							fades_heard++;
						end
					end
					due_samples.push_back('{sample: 16'(res), active: sounding_r});
				end
			end
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string what);
		$display("%0t: mismatch, %s", $time, what);
		failures++;
	endtask

	initial begin
		for (int i = 0; i < SINE_TABLE_DEPTH; i++)
			sine_rom[i] = sine_point(i);
	end

	// channel monitor: configuration, then output words, then input words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_r = '0;
			level_r = '0;
			phase_r = '0;
			step_r = '0;
			gain_r = '0;
			releasing_r = 1'b0;
			sounding_r = 1'b0;
			due_samples.delete();
			failures = 0;
			words_seen = 0;
			samples_checked = 0;
			fades_heard = 0;
			shapes_heard = '0;
			wrapped = 1'b0;
		end else begin
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WAVE_SHAPE:   shape_r = cfg_data[2:0];
					REG_OUTPUT_LEVEL: level_r = cfg_data;
					default: ;
				endcase
			end
			// output word against the oldest prediction
			if (out_valid && !out_stall) begin
				if (due_samples.size() == 0) begin
					flag_mismatch($sformatf("unexpected word, sample %0d active %0b",
						sample_value, voice_active));
				end else begin
					oldest = due_samples.pop_front();
					if (sample_value !== oldest.sample)
						flag_mismatch($sformatf("sample_value %0d, predicted %0d",
							sample_value, oldest.sample));
					if (voice_active !== oldest.active)
						flag_mismatch($sformatf("voice_active %0b, predicted %0b",
							voice_active, oldest.active));
					samples_checked++;
				end
			end
			// input word into the predictor
			if (in_valid && !in_stall) begin
				predict_voice_word(kind_t'(kind), note_number);
				words_seen++;
			end
			// end of run accounting
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (due_samples.size() != 0)
					flag_mismatch($sformatf("%0d predicted words never came out",
						due_samples.size()));
				$display("covered %0d input words and %0d output words, %0d of 8 %s",
					words_seen, samples_checked, $countones(shapes_heard),
					"shape codes heard");
				$display("%0d release fades ran out to silence, %0d mismatches",
					fades_heard, failures);
			end
		end
		pending = due_samples.size();
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// testbench top for the multiwave oscillator voice: clock, reset, stimulus
// and verdict; depends on mwo_pkg, mwo_checker and the voice top level

module tb;
	import mwo_pkg::*;

	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	localparam int RUN_WORDS     = 530;
	localparam int FADE_TICKS    = 320;
	localparam int HOLD_CYCLES   = 160;
	localparam int SETTLE_CYCLES = 12;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            kind;
	logic [6:0]            note_number;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [15:0]    sample_value;
	logic                  voice_active;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  wrap_up;
	int                    pending;
	int                    failures;
	int                    words_sent;
	bit                    quiet;
	bit                    hold_request;

	multiwave_oscillator_with_release_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.note_number  (note_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_value (sample_value),
		.voice_active (voice_active),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mwo_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.note_number  (note_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_value (sample_value),
		.voice_active (voice_active),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.wrap_up      (wrap_up),
		.pending      (pending),
		.failures     (failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 10);
			end
		end
	end

	// offer one word, with an occasional gap first, and wait until taken
	task automatic push_word(input kind_t k, input logic [6:0] n);
		if (!quiet && $urandom_range(99) < 10) begin
			@(negedge clk);
			in_valid <= 1'b0;
			kind <= 2'($urandom);
			note_number <= 7'($urandom);
			repeat ($urandom_range(6)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		note_number <= n;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending, let every sample drain and the block go idle
	task automatic drain_voice();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// idle the block and load both registers; junk above the shape bits
	task automatic set_voice(input logic [2:0] shape_code, input logic [15:0] level);
		drain_voice();
		write_reg(REG_WAVE_SHAPE, {13'($urandom), shape_code});
		write_reg(REG_OUTPUT_LEVEL, level);
	endtask

	// mostly well-formed notes with random content, some noise
	task automatic play_phrase(input int words, input bit squeeze);
		int left;
		int r;
		int t;
		left = words;
		while (left > 0) begin
			r = $urandom_range(99);
			if (r < 75) begin
				// note on, ticks, maybe a release with its own ticks
				push_word(KIND_NOTE_ON, 7'($urandom));
				if (squeeze) begin
					hold_request = 1'b1;
					squeeze = 1'b0;
					t = 12;
				end else begin
					t = $urandom_range(12, 2);
				end
				repeat (t) push_word(KIND_TICK, 7'($urandom));
				left -= t + 1;
				if ($urandom_range(1) == 1) begin
					push_word(KIND_NOTE_REL, 7'($urandom));
					t = $urandom_range(10, 1);
					repeat (t) push_word(KIND_TICK, 7'($urandom));
					left -= t + 1;
					if ($urandom_range(3) == 0) begin
						push_word(KIND_NOTE_REL, 7'($urandom));
						push_word(KIND_TICK, 7'($urandom));
						left -= 2;
					end
				end
			end else if (r < 88) begin
				// cut the voice dead, then a tick on silence
				push_word(KIND_NOTE_OFF, 7'($urandom));
				push_word(KIND_TICK, 7'($urandom));
				left -= 2;
			end else begin
				push_word(kind_t'($urandom_range(3)), 7'($urandom));
				left--;
			end
		end
	endtask

	initial begin : stimulus
		int phase;
		logic [2:0] shape_code;
		logic [15:0] level;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		note_number = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_WAVE_SHAPE;
		cfg_data = '0;
		wrap_up = 1'b0;
		quiet = 1'b0;
		hold_request = 1'b0;
		words_sent = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed: corner notes, every word kind, the odd release cases
		set_voice(SHAPE_SINE, 16'd32768);
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h5A5A);
		push_word(KIND_TICK, 7'd0);
		push_word(KIND_NOTE_REL, 7'd127);
		push_word(KIND_NOTE_ON, 7'd69);
		repeat (3) push_word(KIND_TICK, 7'd127);
		push_word(KIND_NOTE_ON, 7'd127);
		repeat (2) push_word(KIND_TICK, 7'd0);
		push_word(KIND_NOTE_ON, 7'd0);
		push_word(KIND_TICK, 7'd0);
		push_word(KIND_NOTE_REL, 7'd0);
		repeat (2) push_word(KIND_TICK, 7'd0);
		push_word(KIND_NOTE_REL, 7'd127);
		push_word(KIND_TICK, 7'd0);
		push_word(KIND_NOTE_OFF, 7'd127);
		push_word(KIND_TICK, 7'd0);
		push_word(KIND_NOTE_ON, 7'd60);
		push_word(KIND_TICK, 7'd0);

		// random phases, each with its own shape and level
		phase = 0;
		while (words_sent < RUN_WORDS) begin
			shape_code = (phase < 8) ? 3'(phase) : 3'($urandom);
			case ($urandom_range(7))
				0: level = 16'd0;
				1: level = 16'd32768;
				2: level = 16'd1;
				default: level = 16'($urandom_range(32768));
			endcase
			if (phase == 4)
				level = 16'd32768;
			quiet = (phase == 1 || phase == 2);
			set_voice(shape_code, level);
			if (phase == 4) begin
				// one release played out to silence, then ticks on the dead voice
				push_word(KIND_NOTE_ON, 7'($urandom));
				repeat (4) push_word(KIND_TICK, 7'($urandom));
				push_word(KIND_NOTE_REL, 7'($urandom));
				repeat (FADE_TICKS) push_word(KIND_TICK, 7'($urandom));
				push_word(KIND_NOTE_ON, 7'($urandom));
				repeat (3) push_word(KIND_TICK, 7'($urandom));
			end else begin
				play_phrase($urandom_range(50, 30), phase == 3);
			end
			phase++;
		end
		quiet = 1'b0;

		// drain, settle, verdict
		drain_voice();
		wrap_up <= 1'b1;
		repeat (2) @(negedge clk);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
